// ===== rtl/core/cfhb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfhb_pkg
// Shared types, constants and small functions of the column-fold hash block.
// ----------------------------------------------------------------------------
package cfhb_pkg;

  localparam int COLUMNS_DEF   = 20;
  localparam int GROUP_LEN_DEF = 4;
  localparam int KEY_LEN       = 22;

  localparam logic [7:0] DASH_CHAR = 8'h2D;

  // Key characters already reduced modulo 36, one per key position.
  localparam logic [5:0] KEY_MOD [KEY_LEN] = '{
    6'd32, 6'd3,  6'd2,  6'd31, 6'd34, 6'd33, 6'd2,  6'd31,
    6'd9,  6'd0,  6'd25, 6'd2,  6'd8,  6'd3,  6'd2,  6'd28,
    6'd25, 6'd9,  6'd13, 6'd21, 6'd12, 6'd18
  };

  typedef enum logic {
    ST_ACCUM,
    ST_DRAIN
  } state_e;

  // Control broadcast from the controller to every cell.
  typedef struct packed {
    logic accept;  // a byte is accepted this cycle
    logic shift;   // column values move one cell toward the head
    logic load;    // columns and pointer return to their reset values
  } cell_ctrl_t;

  // Remainder modulo 36 of a value below 291, by a reciprocal multiply
  // and one correcting subtraction.
  function automatic logic [5:0] mod36(input logic [8:0] x);
    logic [14:0] p;
    logic [3:0]  q;
    logic [9:0]  r;
    p = 15'(x) * 15'd57;
    q = p[14:11];
    r = 10'(x) - 10'(q) * 10'd36;
    if (r >= 10'd36) begin
      r = r - 10'd36;
    end
    return r[5:0];
  endfunction

  // Character of the table 0-9A-Z at a value below 36.
  function automatic logic [7:0] digit_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd10) begin
      c = 8'h30 + 8'(v);
    end else begin
      c = 8'h37 + 8'(v);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/cfhb_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfhb_cell
// One column of the hash: a running sum modulo 36 and a share of the
// one-hot column pointer, both passed along the chain.
// ----------------------------------------------------------------------------
module cfhb_cell
  import cfhb_pkg::*;
#(
  parameter logic [5:0] KEY     = 6'd0,
  parameter bit         IS_HEAD = 1'b0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic [7:0] byte_i,
  input  logic [5:0] nbr_sum_i,
  input  logic       nbr_tok_i,
  output logic [5:0] sum_o,
  output logic       tok_o
);

  logic [5:0] sum_q, sum_d;
  logic       tok_q, tok_d;

  always_comb begin
    sum_d = sum_q;
    tok_d = tok_q;
    if (ctrl_i.load) begin
      sum_d = KEY;
      tok_d = IS_HEAD;
    end else if (ctrl_i.shift) begin
      sum_d = nbr_sum_i;
    end else if (ctrl_i.accept) begin
      if (tok_q) begin
        sum_d = mod36({3'b000, sum_q} + {1'b0, byte_i});
      end
      tok_d = nbr_tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= KEY;
      tok_q <= IS_HEAD;
    end else begin
      sum_q <= sum_d;
      tok_q <= tok_d;
    end
  end

  assign sum_o = sum_q;
  assign tok_o = tok_q;

endmodule

// ===== rtl/core/cfhb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfhb_ctrl
// Input handshake, drain sequencing with dash insertion, output register.
// ----------------------------------------------------------------------------
module cfhb_ctrl
  import cfhb_pkg::*;
#(
  parameter int COLUMNS   = COLUMNS_DEF,
  parameter int GROUP_LEN = GROUP_LEN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       is_last_i,
  output logic       in_ready_o,
  input  logic [5:0] head_sum_i,
  output cell_ctrl_t ctrl_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o
);

  localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int GRP_W = (GROUP_LEN > 1) ? $clog2(GROUP_LEN) : 1;

  state_e            state_q, state_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [GRP_W-1:0]  grp_q, grp_d;
  logic              dash_q, dash_d;
  logic              ovalid_q, ovalid_d;
  logic [7:0]        ochar_q, ochar_d;
  logic              olast_q, olast_d;

  logic accept;
  logic slot_free;
  logic last_col;

  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !ovalid_q || out_ready_i;
  assign last_col  = (col_q == COL_W'(COLUMNS - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_ACCUM: if (accept && is_last_i) state_d = ST_DRAIN;
      ST_DRAIN: if (slot_free && !dash_q && last_col) state_d = ST_ACCUM;
      default:  state_d = ST_ACCUM;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    in_ready_o   = 1'b0;
    ctrl_o       = '0;
    col_d        = col_q;
    grp_d        = grp_q;
    dash_d       = dash_q;
    ovalid_d     = ovalid_q && !out_ready_i;
    ochar_d      = ochar_q;
    olast_d      = olast_q;
    unique case (state_q)
      ST_ACCUM: begin
        in_ready_o    = 1'b1;
        ctrl_o.accept = accept;
      end
      ST_DRAIN: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          if (dash_q) begin
            ochar_d = DASH_CHAR;
            olast_d = 1'b0;
            dash_d  = 1'b0;
          end else begin
            ochar_d      = digit_char(head_sum_i);
            olast_d      = last_col;
            ctrl_o.shift = 1'b1;
            if (last_col) begin
              // Name complete: columns go back to the key, the pointer to the head cell.
              ctrl_o.load = 1'b1;
              col_d       = '0;
              grp_d       = '0;
            end else begin
              col_d = col_q + 1'b1;
              if (grp_q == GRP_W'(GROUP_LEN - 1)) begin
                grp_d  = '0;
                dash_d = 1'b1;
              end else begin
                grp_d = grp_q + 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_ACCUM;
      col_q    <= '0;
      grp_q    <= '0;
      dash_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      col_q    <= col_d;
      grp_q    <= grp_d;
      dash_q   <= dash_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_char_o  = ochar_q;
  assign out_last_o  = olast_q;

endmodule

// ===== rtl/core/column_fold_hash_base36.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_fold_hash_base36
// Folds a byte string into COLUMNS base-36 columns and emits the hash name.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle; each goes into the column cell that holds
// the pointer token, which then moves to the next cell. On the byte marked
// last the input stalls while the name drains out: one character per cycle
// when the output is taken, COLUMNS digits plus a dash before each group of
// GROUP_LEN columns after the first (24 characters at the defaults), the column
// values shifting toward the head cell one step per digit. The input reopens
// on the cycle after the last digit leaves the chain, with all columns back
// at their key values.
module column_fold_hash_base36
  import cfhb_pkg::*;
#(
  parameter int COLUMNS   = COLUMNS_DEF,
  parameter int GROUP_LEN = GROUP_LEN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o
);

  cell_ctrl_t ctrl;
  logic [5:0] sums [COLUMNS];
  logic       toks [COLUMNS];

  cfhb_ctrl #(
    .COLUMNS   (COLUMNS),
    .GROUP_LEN (GROUP_LEN)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .is_last_i   (is_last_i),
    .in_ready_o  (in_ready_o),
    .head_sum_i  (sums[0]),
    .ctrl_o      (ctrl),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .out_last_o  (out_last_o)
  );

  for (genvar i = 0; i < COLUMNS; i++) begin : g_cell
    localparam int KI   = i % KEY_LEN;
    localparam int NEXT = (i + 1) % COLUMNS;
    localparam int PREV = (i + COLUMNS - 1) % COLUMNS;

    cfhb_cell #(
      .KEY     (KEY_MOD[KI]),
      .IS_HEAD (i == 0)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .byte_i    (data_byte_i),
      .nbr_sum_i (sums[NEXT]),
      .nbr_tok_i (toks[PREV]),
      .sum_o     (sums[i]),
      .tok_o     (toks[i])
    );
  end

endmodule

// ===== rtl/core/cfhb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfhb_checker
// Port-level checks of the column-fold hash block, bound to the top level.
// ----------------------------------------------------------------------------
module cfhb_checker
  import cfhb_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] data_byte_i,
  input logic       is_last_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_char_o,
  input logic       out_last_o
);

  // A waiting item holds its character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_char_o))
    else $error("output item changed while stalled");

  // The last byte of a string closes the input while the name drains.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && is_last_i |=> !in_ready_o)
    else $error("input open right after last byte");

  // Every character is a digit, an upper-case letter or a dash.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_char_o >= 8'h30 && out_char_o <= 8'h39) ||
                    (out_char_o >= 8'h41 && out_char_o <= 8'h5A) ||
                    (out_char_o == DASH_CHAR))
    else $error("illegal name character");

  // A name never ends on a dash.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_last_o |-> out_char_o != DASH_CHAR)
    else $error("name ends on a dash");

endmodule

bind column_fold_hash_base36 cfhb_checker u_cfhb_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the column-fold base-36 hash block.
// ----------------------------------------------------------------------------
// Byte strings go in through the valid/ready input. A behavioral copy of the
// column sums predicts each 24-character name, and every output item is
// compared in order against it. Both sides idle at random, and the output
// side holds off once for a long stretch so that the input backs up.
// ----------------------------------------------------------------------------
module testbench;
  import cfhb_pkg::*;

  localparam int NUM_COLS     = 20;
  localparam int GROUP        = 4;
  localparam int KEY_CHARS    = 22;
  localparam int BASE         = 36;
  localparam int NUM_DIRECTED = 24;
  localparam int RAND_ITEMS   = 426;
  localparam int IDLE_PCT     = 27;
  localparam int HOLD_START   = 40;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_WAIT   = 40;
  localparam int MAX_CYCLES   = 300000;
  localparam int MAX_SHOWN    = 10;

  // ASCII codes of the key string, first character in the top byte.
  localparam logic [KEY_CHARS*8-1:0] KEY_BYTES = {
    8'h68, 8'h6F, 8'h6E, 8'h67, 8'h6A, 8'h69, 8'h6E, 8'h67, 8'h2D, 8'h6C, 8'h61,
    8'h6E, 8'h74, 8'h6F, 8'h6E, 8'h64, 8'h61, 8'h2D, 8'h31, 8'h39, 8'h30, 8'h36
  };
  localparam logic [BASE*8-1:0] ALNUM = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

  // Name produced when every column still holds its key value.
  localparam string KEY_NAME = "W32V-YX2V-90P2-832S-P9DL";
  localparam string TOP_NAME = "Z32V-YX2V-90P2-832S-P9DL";

  // One walking pattern per bit, then its complement, then mixed bytes:
  // 21 bytes, so column 0 receives a second byte.
  localparam int WRAP_LEN = 21;
  localparam logic [WRAP_LEN*8-1:0] WRAP_BYTES = {
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'hFE, 8'hFD, 8'hFB,
    8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h7F, 8'h55, 8'hAA, 8'h33, 8'hCC, 8'h99
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } name_char_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic       is_last = 1'b0;
  logic       out_ready = 1'b0;
  wire        in_ready;
  wire        out_valid;
  wire  [7:0] out_char;
  wire        out_last;

  column_fold_hash_base36 dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .data_byte_i (data_byte),
    .is_last_i   (is_last),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_char_o  (out_char),
    .out_last_o  (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [5:0]  col_sum [NUM_COLS];
  int          col_ptr;
  name_char_t  name_q[$];

  int          acc_cnt = 0;
  int          cycle_cnt = 0;
  int          err_cnt = 0;
  int          chars_checked = 0;
  int          bytes_sent = 0;
  int          strings_sent = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;

  // A stretch of the run where neither side idles.
  wire quiet = (acc_cnt >= 200) && (acc_cnt < 300);

  function automatic void clear_columns();
    for (int c = 0; c < NUM_COLS; c++) begin
      col_sum[c] = 6'(KEY_BYTES[(KEY_CHARS - 1 - (c % KEY_CHARS))*8 +: 8] % BASE);
    end
    col_ptr = 0;
  endfunction

  // Adds one byte into its column; on the last byte the name is queued and
  // the columns go back to the key values. A nonempty typed name replaces
  // the computed one.
  function automatic void fold_byte(input logic [7:0] b, input logic l, input string typed);
    name_char_t nc;
    col_sum[col_ptr] = 6'((int'(col_sum[col_ptr]) + int'(b)) % BASE);
    col_ptr = (col_ptr + 1) % NUM_COLS;
    if (l) begin
      if (typed.len() != 0) begin
        for (int i = 0; i < typed.len(); i++) begin
          nc.ch = typed[i];
          nc.last = (i == typed.len() - 1);
          name_q = {name_q, nc};
        end
      end else begin
        for (int c = 0; c < NUM_COLS; c++) begin
          if (c != 0 && c % GROUP == 0) begin
            nc.ch = DASH_CHAR;
            nc.last = 1'b0;
            name_q = {name_q, nc};
          end
          nc.ch = ALNUM[(BASE - 1 - int'(col_sum[c]))*8 +: 8];
          nc.last = (c == NUM_COLS - 1);
          name_q = {name_q, nc};
        end
      end
      clear_columns();
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic l, input string typed);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    is_last   <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    fold_byte(b, l, typed);
    bytes_sent++;
    if (l) strings_sent++;
  endtask

  always @(posedge clk) begin
    if (in_valid && in_ready) acc_cnt <= acc_cnt + 1;
  end

  // Output side: random stalls, plus one long hold-off while input keeps coming.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && acc_cnt >= HOLD_START) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_names
    name_char_t want;
    if (rst_n && out_valid && out_ready) begin
      if (name_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_SHOWN) begin
          $display("Unexpected output item: char %h last %b", out_char, out_last);
        end
      end else begin
        want = name_q.pop_front();
        chars_checked++;
        if (out_char !== want.ch || out_last !== want.last) begin
          err_cnt++;
          if (err_cnt <= MAX_SHOWN) begin
            $display("Mismatch at char %0d: expected %h last %b, got %h last %b",
                     chars_checked, want.ch, want.last, out_char, out_last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == MAX_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [7:0] b;
    logic       l;
    string      typed;
    int         sel;
    int         len;
    clear_columns();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows: lone bytes 0x00, 0xFF and 0x24, then a string that wraps.
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      typed = "";
      case (r)
        0: begin
          b = 8'h00;
          l = 1'b1;
          typed = KEY_NAME;
        end
        1: begin
          b = 8'hFF;
          l = 1'b1;
          typed = TOP_NAME;
        end
        2: begin
          b = 8'h24;
          l = 1'b1;
          typed = KEY_NAME;
        end
        default: begin
          b = WRAP_BYTES[(WRAP_LEN - 1 - (r - 3))*8 +: 8];
          l = (r == NUM_DIRECTED - 1);
        end
      endcase
      send_byte(b, l, typed);
    end

    // Random strings, mostly short, some wrapping the columns several times.
    while (bytes_sent < NUM_DIRECTED + RAND_ITEMS) begin
      sel = $urandom_range(99);
      if (sel < 70) len = $urandom_range(8, 1);
      else if (sel < 90) len = $urandom_range(25, 9);
      else len = $urandom_range(60, 26);
      // The final string is cut short so the run ends on the item budget.
      if (len > NUM_DIRECTED + RAND_ITEMS - bytes_sent) begin
        len = NUM_DIRECTED + RAND_ITEMS - bytes_sent;
      end
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(7))
          0: b = 8'h00;
          1: b = 8'hFF;
          default: b = 8'($urandom);
        endcase
        send_byte(b, k == len - 1, "");
      end
    end
    in_valid <= 1'b0;

    while (name_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Folded %0d bytes in %0d strings; %0d name characters compared, %0d errors.",
             bytes_sent, strings_sent, chars_checked, err_cnt);
    $display("Output was held off for %0d cycles once while bytes kept arriving.",
             HOLD_CYCLES);
    if (err_cnt == 0 && name_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/cfhb_pkg.sv
rtl/core/cfhb_cell.sv
rtl/core/cfhb_ctrl.sv
rtl/core/column_fold_hash_base36.sv
rtl/core/cfhb_checker.sv
tb/testbench.sv
